/* src/fbde_pkg.sv */
// Package for the framebuffer drawing engine: request/result types, opcodes,
// state codes and the 6x8 glyph table. No dependencies.
`default_nettype none
package fbde_pkg;

    localparam int DefScreenWidth  = 240;
    localparam int DefScreenHeight = 135;
    localparam int GlyphW = 6;
    localparam int GlyphH = 8;

    typedef enum logic [2:0] {
        OP_CLEAR     = 3'd0,
        OP_PIXEL     = 3'd1,
        OP_RECT      = 3'd2,
        OP_FILL      = 3'd3,
        OP_TEXT      = 3'd4,
        OP_CHAR      = 3'd5,
        OP_READ      = 3'd6,
        OP_NONE      = 3'd7
    } opcode_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [8:0]  pos_x;
        logic [8:0]  pos_y;
        logic [8:0]  box_width;
        logic [8:0]  box_height;
        logic [15:0] fore_color;
        logic [15:0] back_color;
        logic [7:0]  char_code;
    } req_t;

    typedef struct packed {
        logic [15:0] read_color;
        logic        text_halted;
    } rsp_t;

    typedef enum logic [6:0] {
        ST_WIPE  = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_SWEEP = 7'b0000100,
        ST_RD    = 7'b0001000,
        ST_RDW   = 7'b0010000,
        ST_RDO   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    // Column byte of a glyph; index is code-32, column 0..5.
    function automatic logic [7:0] glyph_col(input logic [6:0] idx, input logic [2:0] col);
        logic [47:0] g;
        begin
            case (idx)
                7'd0:  g = 48'h00_00_00_00_00_00;
                7'd1:  g = 48'h00_00_5F_00_00_00;
                7'd2:  g = 48'h00_07_00_07_00_00;
                7'd3:  g = 48'h14_7F_14_7F_14_00;
                7'd4:  g = 48'h24_2A_7F_2A_12_00;
                7'd5:  g = 48'h23_13_08_64_62_00;
                7'd6:  g = 48'h36_49_55_22_50_00;
                7'd7:  g = 48'h00_05_03_00_00_00;
                7'd8:  g = 48'h00_1C_22_41_00_00;
                7'd9:  g = 48'h00_41_22_1C_00_00;
                7'd10: g = 48'h14_08_3E_08_14_00;
                7'd11: g = 48'h08_08_3E_08_08_00;
                7'd12: g = 48'h00_50_30_00_00_00;
                7'd13: g = 48'h08_08_08_08_08_00;
                7'd14: g = 48'h00_60_60_00_00_00;
                7'd15: g = 48'h20_10_08_04_02_00;
                7'd16: g = 48'h3E_51_49_45_3E_00;
                7'd17: g = 48'h00_42_7F_40_00_00;
                7'd18: g = 48'h42_61_51_49_46_00;
                7'd19: g = 48'h21_41_45_4B_31_00;
                7'd20: g = 48'h18_14_12_7F_10_00;
                7'd21: g = 48'h27_45_45_45_39_00;
                7'd22: g = 48'h3C_4A_49_49_30_00;
                7'd23: g = 48'h01_71_09_05_03_00;
                7'd24: g = 48'h36_49_49_49_36_00;
                7'd25: g = 48'h06_49_49_29_1E_00;
                7'd26: g = 48'h00_36_36_00_00_00;
                7'd27: g = 48'h00_56_36_00_00_00;
                7'd28: g = 48'h08_14_22_41_00_00;
                7'd29: g = 48'h14_14_14_14_14_00;
                7'd30: g = 48'h00_41_22_14_08_00;
                7'd31: g = 48'h02_01_51_09_06_00;
                7'd32: g = 48'h32_49_79_41_3E_00;
                7'd33: g = 48'h7E_11_11_11_7E_00;
                7'd34: g = 48'h7F_49_49_49_36_00;
                7'd35: g = 48'h3E_41_41_41_22_00;
                7'd36: g = 48'h7F_41_41_22_1C_00;
                7'd37: g = 48'h7F_49_49_49_41_00;
                7'd38: g = 48'h7F_09_09_09_01_00;
                7'd39: g = 48'h3E_41_49_49_7A_00;
                7'd40: g = 48'h7F_08_08_08_7F_00;
                7'd41: g = 48'h00_41_7F_41_00_00;
                7'd42: g = 48'h20_40_41_3F_01_00;
                7'd43: g = 48'h7F_08_14_22_41_00;
                7'd44: g = 48'h7F_40_40_40_40_00;
                7'd45: g = 48'h7F_02_0C_02_7F_00;
                7'd46: g = 48'h7F_04_08_10_7F_00;
                7'd47: g = 48'h3E_41_41_41_3E_00;
                7'd48: g = 48'h7F_09_09_09_06_00;
                7'd49: g = 48'h3E_41_51_21_5E_00;
                7'd50: g = 48'h7F_09_19_29_46_00;
                7'd51: g = 48'h46_49_49_49_31_00;
                7'd52: g = 48'h01_01_7F_01_01_00;
                7'd53: g = 48'h3F_40_40_40_3F_00;
                7'd54: g = 48'h1F_20_40_20_1F_00;
                7'd55: g = 48'h3F_40_38_40_3F_00;
                7'd56: g = 48'h63_14_08_14_63_00;
                7'd57: g = 48'h07_08_70_08_07_00;
                7'd58: g = 48'h61_51_49_45_43_00;
                7'd59: g = 48'h00_7F_41_41_00_00;
                7'd60: g = 48'h02_04_08_10_20_00;
                7'd61: g = 48'h00_41_41_7F_00_00;
                7'd62: g = 48'h04_02_01_02_04_00;
                7'd63: g = 48'h40_40_40_40_40_00;
                7'd64: g = 48'h00_01_02_04_00_00;
                7'd65: g = 48'h20_54_54_54_78_00;
                7'd66: g = 48'h7F_48_44_44_38_00;
                7'd67: g = 48'h38_44_44_44_20_00;
                7'd68: g = 48'h38_44_44_48_7F_00;
                7'd69: g = 48'h38_54_54_54_18_00;
                7'd70: g = 48'h08_7E_09_01_02_00;
                7'd71: g = 48'h0C_52_52_52_3E_00;
                7'd72: g = 48'h7F_08_04_04_78_00;
                7'd73: g = 48'h00_44_7D_40_00_00;
                7'd74: g = 48'h20_40_44_3D_00_00;
                7'd75: g = 48'h7F_10_28_44_00_00;
                7'd76: g = 48'h00_41_7F_40_00_00;
                7'd77: g = 48'h7C_04_18_04_78_00;
                7'd78: g = 48'h7C_08_04_04_78_00;
                7'd79: g = 48'h38_44_44_44_38_00;
                7'd80: g = 48'h7C_14_14_14_08_00;
                7'd81: g = 48'h08_14_14_18_7C_00;
                7'd82: g = 48'h7C_08_04_04_08_00;
                7'd83: g = 48'h48_54_54_54_20_00;
                7'd84: g = 48'h04_3F_44_40_20_00;
                7'd85: g = 48'h3C_40_40_20_7C_00;
                7'd86: g = 48'h1C_20_40_20_1C_00;
                7'd87: g = 48'h3C_40_30_40_3C_00;
                7'd88: g = 48'h44_28_10_28_44_00;
                7'd89: g = 48'h0C_50_50_50_3C_00;
                7'd90: g = 48'h44_64_54_4C_44_00;
                7'd91: g = 48'h00_08_36_41_00_00;
                7'd92: g = 48'h00_00_7F_00_00_00;
                7'd93: g = 48'h00_41_36_08_00_00;
                7'd94: g = 48'h08_08_2A_1C_08_00;
                default: g = 48'h02_01_51_09_06_00;
            endcase
            case (col)
                3'd0:    glyph_col = g[47:40];
                3'd1:    glyph_col = g[39:32];
                3'd2:    glyph_col = g[31:24];
                3'd3:    glyph_col = g[23:16];
                3'd4:    glyph_col = g[15:8];
                default: glyph_col = g[7:0];
            endcase
        end
    endfunction

endpackage
`default_nettype wire

/* src/fbde_store.sv */
// Frame store memory: one write port, one registered read port.
// Depends on fbde_pkg only for the parameter defaults.
`default_nettype none
module fbde_store
    import fbde_pkg::*;
#(
    parameter int Depth = DefScreenWidth * DefScreenHeight,
    localparam int AW = $clog2(Depth)
)(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [15:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [15:0]        rdata
);

    logic [15:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* src/framebuffer_drawing_engine.sv */
// Framebuffer drawing engine, top level. Uses fbde_pkg and fbde_store.
// A drawing request sweeps its pixels (clear W*H, box and outline clipped
// w*h, glyph 6x8, a pixel request a single pixel); a read passes states RD,
// RDW and RDO; the rest go straight to the output. A request is taken only
// in the idle state, i.e. after the last result has been taken. Reset:
// asynchronous; a wipe pass blacks the whole store, no request is taken meanwhile.
`default_nettype none
module framebuffer_drawing_engine
    import fbde_pkg::*;
#(
    parameter int ScreenWidth  = DefScreenWidth,
    parameter int ScreenHeight = DefScreenHeight
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire req_t in_data,
    output logic      out_valid,
    input  wire logic out_stall,
    output rsp_t      out_data
);

    localparam int Pixels = ScreenWidth * ScreenHeight;
    localparam int AW = $clog2(Pixels);
    localparam logic [9:0] SW = 10'(ScreenWidth);
    localparam logic [9:0] SH = 10'(ScreenHeight);

    state_t state_reg, state_next;
    // sweep walks rows y0..y1 and columns x0..x1
    logic [8:0] x0_reg, x1_reg, y1_reg;
    logic [8:0] cx_reg, cy_reg;
    logic [AW-1:0] row_base_reg;          // cy*W
    logic       outline_reg, glyph_reg;
    logic [15:0] fg_reg, bg_reg;
    logic [6:0] gidx_reg;
    logic [8:0] cur_col_reg, cur_row_reg;
    logic       halted_reg;
    logic [15:0] rd_reg;
    logic [AW-1:0] raddr_reg;
    logic [AW-1:0] wipe_reg;

    logic          we;
    logic [AW-1:0] waddr;
    logic [15:0]   wdata;
    logic [15:0]   rdata;

    fbde_store #(.Depth(Pixels)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr_reg),
        .rdata (rdata)
    );

    wire logic [9:0] xe = 10'(in_data.pos_x) + 10'(in_data.box_width);
    wire logic [9:0] ye = 10'(in_data.pos_y) + 10'(in_data.box_height);
    wire logic [8:0] xl = (xe > SW) ? 9'(SW - 10'd1) : 9'(xe - 10'd1);
    wire logic [8:0] yl = (ye > SH) ? 9'(SH - 10'd1) : 9'(ye - 10'd1);
    wire logic on_scr = (10'(in_data.pos_x) < SW) && (10'(in_data.pos_y) < SH);
    wire logic box_ok = on_scr && (in_data.box_width != 9'd0) && (in_data.box_height != 9'd0);
    wire logic g_fit = (10'(cur_col_reg) + 10'(GlyphW) <= SW)
                       && (10'(cur_row_reg) + 10'(GlyphH) <= SH);
    wire logic [7:0] cc = in_data.char_code;
    wire logic [6:0] cidx = (cc < 8'd32 || cc > 8'd126) ? 7'd31 : 7'(cc - 8'd32);

    // sweep decode
    wire logic last_x = (cx_reg == x1_reg);
    wire logic last_y = (cy_reg == y1_reg);
    wire logic on_edge = last_x || last_y || (cx_reg == x0_reg);
    logic first_row_reg;
    wire logic [7:0] gcol = glyph_col(gidx_reg, 3'(cx_reg - x0_reg));
    wire logic [2:0] grow = 3'(cy_reg - cur_row_reg);
    wire logic [AW-1:0] sweep_addr = row_base_reg + AW'(cx_reg);
    wire logic draw_now = !outline_reg || on_edge || first_row_reg;

    // sweep box of the request on the input
    logic [8:0] sx0, sy0, sx1, sy1;

    always_comb
    begin
        sx0 = in_data.pos_x;
        sy0 = in_data.pos_y;
        sx1 = xl;
        sy1 = yl;
        case (opcode_t'(in_data.opcode))
            OP_CLEAR:
            begin
                sx0 = '0;
                sy0 = '0;
                sx1 = 9'(SW - 10'd1);
                sy1 = 9'(SH - 10'd1);
            end
            OP_PIXEL:
            begin
                sx1 = in_data.pos_x;
                sy1 = in_data.pos_y;
            end
            OP_CHAR:
            begin
                sx0 = cur_col_reg;
                sy0 = cur_row_reg;
                sx1 = 9'(cur_col_reg + 9'(GlyphW - 1));
                sy1 = 9'(cur_row_reg + 9'(GlyphH - 1));
            end
            default: ;
        endcase
    end

    always_comb
    begin
        we = 1'b0;
        waddr = sweep_addr;
        wdata = fg_reg;
        if (state_reg == ST_WIPE)
        begin
            we = 1'b1;
            waddr = wipe_reg;
            wdata = 16'h0000;
        end
        else if (state_reg == ST_SWEEP)
        begin
            we = draw_now;
            if (glyph_reg)
            begin
                wdata = gcol[grow] ? fg_reg : bg_reg;
            end
        end
    end

    wire logic accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_data.read_color = rd_reg;
    assign out_data.text_halted = halted_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_WIPE:  if (wipe_reg == AW'(Pixels - 1)) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_OUT;
                    case (opcode_t'(in_data.opcode))
                        OP_CLEAR: state_next = ST_SWEEP;
                        OP_PIXEL, OP_RECT, OP_FILL: if (box_ok || (on_scr &&
                            in_data.opcode == OP_PIXEL)) state_next = ST_SWEEP;
                        OP_CHAR: if (!halted_reg && g_fit) state_next = ST_SWEEP;
                        OP_READ: if (on_scr) state_next = ST_RD;
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_SWEEP: if (last_x && last_y) state_next = ST_OUT;
            ST_RD:    state_next = ST_RDW;
            ST_RDW:   state_next = ST_RDO;
            ST_RDO:   state_next = ST_OUT;
            ST_OUT:   if (!out_stall) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_WIPE;
            wipe_reg    <= '0;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            halted_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_WIPE)
            begin
                wipe_reg <= wipe_reg + AW'(1);
            end
            if (accept && in_data.opcode == OP_TEXT)
            begin
                cur_col_reg <= in_data.pos_x;
                cur_row_reg <= in_data.pos_y;
                halted_reg  <= 1'b0;
            end
            if (accept && in_data.opcode == OP_CHAR && !halted_reg)
            begin
                if (g_fit)
                    cur_col_reg <= 9'(cur_col_reg + 9'(GlyphW));
                else
                    halted_reg <= 1'b1;
            end
        end
    end

    // payload and stepper
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fg_reg <= in_data.fore_color;
            bg_reg <= in_data.back_color;
            gidx_reg <= cidx;
            rd_reg <= 16'h0000;
            outline_reg <= (in_data.opcode == OP_RECT);
            glyph_reg <= (in_data.opcode == OP_CHAR);
            first_row_reg <= 1'b1;
            x0_reg <= sx0;
            cx_reg <= sx0;
            cy_reg <= sy0;
            x1_reg <= sx1;
            y1_reg <= sy1;
            raddr_reg <= AW'(in_data.pos_x);
            // start row base: y*W, one constant multiply per request
            row_base_reg <= AW'(sy0) * AW'(ScreenWidth);
        end
        else if (state_reg == ST_SWEEP)
        begin
            if (last_x)
            begin
                cx_reg <= x0_reg;
                cy_reg <= cy_reg + 9'd1;
                row_base_reg <= row_base_reg + AW'(ScreenWidth);
                first_row_reg <= 1'b0;
            end
            else
            begin
                cx_reg <= cx_reg + 9'd1;
            end
        end
        else if (state_reg == ST_RD)
        begin
            raddr_reg <= raddr_reg + row_base_reg;
        end
        else if (state_reg == ST_RDO)
        begin
            rd_reg <= rdata;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (cx_reg <= x1_reg) && (cy_reg <= y1_reg))
        else $error("sweep outside its box");
    assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (waddr < AW'(Pixels)))
        else $error("store write out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !out_valid || !$past(in_data.opcode == OP_CLEAR))
        else $error("clear finished too early");

endmodule
`default_nettype wire
